>>> hw/rtl/fltw_pkg.sv
// Shared types and constants of the four-level page table walker.
// Depends on nothing; used by the core and its checker.
package fltw_pkg;

    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_TRANSLATE = 2'd1,
        OP_MAP       = 2'd2
    } opcode_t;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NOTPRESENT = 2'd1;
    localparam logic [1:0] STAT_EXHAUSTED  = 2'd2;
    localparam logic [1:0] STAT_OUTSIDE    = 2'd3;

    localparam logic [1:0] PSIZE_4K = 2'd0;
    localparam logic [1:0] PSIZE_2M = 2'd1;
    localparam logic [1:0] PSIZE_1G = 2'd2;

    localparam logic [1:0] CFG_ROOT_PAGE  = 2'd0;
    localparam logic [1:0] CFG_STORE_BASE = 2'd1;
    localparam logic [1:0] CFG_POOL_FIRST = 2'd2;
    localparam logic [1:0] CFG_POOL_COUNT = 2'd3;

    localparam logic [7:0] FLAGS_TABLE = 8'h03;
    localparam logic [7:0] FLAGS_LARGE = 8'h83;
    localparam logic [7:0] FLAGS_NONE  = 8'h00;

    localparam logic [51:0] STEP_1G = 52'h0000040000000;
    localparam logic [51:0] STEP_2M = 52'h0000000200000;
    localparam logic [51:0] STEP_4K = 52'h0000000001000;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ISSUE = 7'b0000010,
        ST_ALIAS = 7'b0000100,
        ST_CHECK = 7'b0001000,
        ST_FILL  = 7'b0010000,
        ST_LINK  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

endpackage

>>> hw/rtl/fltw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
module fltw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/four_level_page_table_walker_core.sv
// Four-level page table walker core: sequencer around one table store RAM.
// Depends on fltw_pkg and fltw_ram.
//
// One beat in gives one beat out. A load goes from acceptance straight to its
// result. A translate visits one level after another, each with one read of
// the single store port, until it reaches a leaf or a fault. A map walks the
// three upper levels the same way, with an extra read of entry zero at the top
// level when the PML4 index is not zero, ends with one write of the final
// entry, and, for each fresh table page it takes from the pool, adds 512
// entry writes through the store's one write port and one write of the
// linking entry. The store is not cleared after reset; entries read before
// they are written hold no defined value.
// The next beat is accepted once the current one is finished, even while its
// result waits in the output register.
module four_level_page_table_walker_core #(
    parameter int TABLE_PAGES    = 64,
    parameter int PHYS_ADDR_BITS = 52
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // virt_addr, map_target_addr, load_page, load_index, load_data, zero pad
    input  logic [183:0] s_axis_tdata,
    // opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, result_addr, page_size
    output logic [55:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [39:0]  cfg_data
);
    import fltw_pkg::*;

    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int ADDR_W = PAGE_W + 9;
    localparam int DEPTH  = TABLE_PAGES * 512;
    localparam int PNW    = PHYS_ADDR_BITS - 12;
    localparam logic [51:0] PHYS_MASK = (52'(1) << PHYS_ADDR_BITS) - 52'(1);
    localparam logic [51:0] MASK_4K   = PHYS_MASK & ~52'hFFF;
    localparam logic [51:0] MASK_2M   = PHYS_MASK & ~52'h1FFFFF;
    localparam logic [51:0] MASK_1G   = PHYS_MASK & ~52'h3FFFFFFF;

    typedef struct packed {
        logic              ok;
        logic [PAGE_W-1:0] page;
    } walk_ptr_t;

    state_t             state_reg, state_next;
    opcode_t            op_reg, op_next;
    logic [47:0]        va_reg, va_next;
    logic [51:0]        tgt_reg, tgt_next;
    logic [1:0]         lvl_reg, lvl_next;
    logic [PAGE_W-1:0]  cur_page_reg, cur_page_next;
    logic [PNW-1:0]     e0_reg, e0_next;
    logic [PAGE_W-1:0]  fresh_reg, fresh_next;
    logic [8:0]         cnt_reg, cnt_next;
    logic [51:0]        acc_reg, acc_next;
    logic [51:0]        step_reg, step_next;
    logic [7:0]         flags_reg, flags_next;
    logic [6:0]         used_reg, used_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [51:0]        res_addr_reg, res_addr_next;
    logic [1:0]         res_size_reg, res_size_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [51:0]        out_addr_reg, out_addr_next;
    logic [1:0]         out_size_reg, out_size_next;

    logic [5:0]         root_reg;
    logic [39:0]        base_reg;
    logic [6:0]         pool_first_reg;
    logic [6:0]         pool_count_reg;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [63:0]        ram_wdata, ram_rdata;

    logic               s_fire;
    logic [8:0]         cur_idx;
    logic [ADDR_W-1:0]  cur_addr;
    walk_ptr_t          e_ptr, link_ptr;
    logic [PNW-1:0]     link_pn;
    logic [63:0]        link_val;
    logic [7:0]         pool_page;
    logic               alias_hit, need_page;

    function automatic walk_ptr_t table_of(logic [63:0] e, logic [39:0] base);
        logic [40:0] diff;
        walk_ptr_t   r;
        diff   = {1'b0, 40'(e[PHYS_ADDR_BITS-1:12])} - {1'b0, base};
        r.ok   = !diff[40] && (diff[39:0] < 40'(TABLE_PAGES));
        r.page = diff[PAGE_W-1:0];
        return r;
    endfunction

    fltw_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_size_reg, out_addr_reg, out_status_reg};

    always_comb
    begin
        case (lvl_reg)
            2'd0:    cur_idx = va_reg[47:39];
            2'd1:    cur_idx = va_reg[38:30];
            2'd2:    cur_idx = va_reg[29:21];
            default: cur_idx = va_reg[20:12];
        endcase
    end

    assign cur_addr  = {cur_page_reg, cur_idx};
    assign e_ptr     = table_of(ram_rdata, base_reg);
    assign link_pn   = PNW'(base_reg + 40'(fresh_reg));
    assign link_val  = 64'({link_pn, 4'h0, FLAGS_TABLE});
    assign link_ptr  = table_of(link_val, base_reg);
    assign pool_page = 8'(pool_first_reg) + 8'(used_reg);
    assign alias_hit = (lvl_reg == 2'd0) && (cur_idx != 9'd0) && ram_rdata[0]
                       && (e0_reg == ram_rdata[PHYS_ADDR_BITS-1:12]);
    assign need_page = alias_hit || !ram_rdata[0] || ((lvl_reg != 2'd0) && ram_rdata[7]);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        va_next         = va_reg;
        tgt_next        = tgt_reg;
        lvl_next        = lvl_reg;
        cur_page_next   = cur_page_reg;
        e0_next         = e0_reg;
        fresh_next      = fresh_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        step_next       = step_reg;
        flags_next      = flags_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_size_next   = res_size_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_size_next   = out_size_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    op_next         = opcode_t'(s_axis_tuser);
                    va_next         = s_axis_tdata[47:0];
                    tgt_next        = s_axis_tdata[99:48];
                    lvl_next        = 2'd0;
                    cur_page_next   = PAGE_W'(root_reg);
                    res_status_next = STAT_OK;
                    res_addr_next   = '0;
                    res_size_next   = PSIZE_4K;
                    state_next      = ST_DONE;
                    case (s_axis_tuser)
                        OP_LOAD:
                        begin
                            if (32'(s_axis_tdata[105:100]) < TABLE_PAGES)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = {PAGE_W'(s_axis_tdata[105:100]),
                                             s_axis_tdata[114:106]};
                                ram_wdata = s_axis_tdata[178:115];
                            end
                        end
                        OP_TRANSLATE, OP_MAP:
                        begin
                            if (32'(root_reg) >= TABLE_PAGES)
                            begin
                                res_status_next = STAT_OUTSIDE;
                            end
                            else
                            begin
                                state_next = ST_ISSUE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ISSUE:
            begin
                if (op_reg == OP_MAP && lvl_reg == 2'd3)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = cur_addr;
                    ram_wdata  = {12'h000, tgt_reg & MASK_4K} | 64'(FLAGS_TABLE);
                    state_next = ST_DONE;
                end
                else if (op_reg == OP_MAP && lvl_reg == 2'd0 && cur_idx != 9'd0)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = {cur_page_reg, 9'd0};
                    state_next = ST_ALIAS;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_addr;
                    state_next = ST_CHECK;
                end
            end
            ST_ALIAS:
            begin
                e0_next    = ram_rdata[PHYS_ADDR_BITS-1:12];
                ram_re     = 1'b1;
                ram_raddr  = cur_addr;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (op_reg == OP_TRANSLATE)
                begin
                    state_next = ST_DONE;
                    if (!ram_rdata[0])
                    begin
                        res_status_next = STAT_NOTPRESENT;
                    end
                    else if (lvl_reg == 2'd1 && ram_rdata[7])
                    begin
                        res_addr_next = (ram_rdata[51:0] & MASK_1G) | 52'(va_reg[29:0]);
                        res_size_next = PSIZE_1G;
                    end
                    else if (lvl_reg == 2'd2 && ram_rdata[7])
                    begin
                        res_addr_next = (ram_rdata[51:0] & MASK_2M) | 52'(va_reg[20:0]);
                        res_size_next = PSIZE_2M;
                    end
                    else if (lvl_reg == 2'd3)
                    begin
                        res_addr_next = (ram_rdata[51:0] & MASK_4K) | 52'(va_reg[11:0]);
                        res_size_next = PSIZE_4K;
                    end
                    else if (!e_ptr.ok)
                    begin
                        res_status_next = STAT_OUTSIDE;
                    end
                    else
                    begin
                        lvl_next      = lvl_reg + 2'd1;
                        cur_page_next = e_ptr.page;
                        state_next    = ST_ISSUE;
                    end
                end
                else
                begin
                    if (alias_hit)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_addr;
                        ram_wdata = '0;
                    end
                    if (need_page)
                    begin
                        if (used_reg >= pool_count_reg)
                        begin
                            res_status_next = STAT_EXHAUSTED;
                            state_next      = ST_DONE;
                        end
                        else if (32'(pool_page) >= TABLE_PAGES)
                        begin
                            res_status_next = STAT_OUTSIDE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            used_next  = used_reg + 7'd1;
                            fresh_next = PAGE_W'(pool_page);
                            cnt_next   = '0;
                            state_next = ST_FILL;
                            if (lvl_reg == 2'd0)
                            begin
                                acc_next   = '0;
                                step_next  = STEP_1G;
                                flags_next = FLAGS_LARGE;
                            end
                            else if (ram_rdata[7] && lvl_reg == 2'd1)
                            begin
                                acc_next   = ram_rdata[51:0] & MASK_1G;
                                step_next  = STEP_2M;
                                flags_next = FLAGS_LARGE;
                            end
                            else if (ram_rdata[7])
                            begin
                                acc_next   = ram_rdata[51:0] & MASK_2M;
                                step_next  = STEP_4K;
                                flags_next = FLAGS_TABLE;
                            end
                            else
                            begin
                                acc_next   = '0;
                                step_next  = '0;
                                flags_next = FLAGS_NONE;
                            end
                        end
                    end
                    else if (!e_ptr.ok)
                    begin
                        res_status_next = STAT_OUTSIDE;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        lvl_next      = lvl_reg + 2'd1;
                        cur_page_next = e_ptr.page;
                        state_next    = ST_ISSUE;
                    end
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = {fresh_reg, cnt_reg};
                ram_wdata = {12'h000, acc_reg} | 64'(flags_reg);
                acc_next  = (acc_reg + step_reg) & PHYS_MASK;
                cnt_next  = cnt_reg + 9'd1;
                if (cnt_reg == '1)
                begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = link_val;
                if (!link_ptr.ok)
                begin
                    res_status_next = STAT_OUTSIDE;
                    state_next      = ST_DONE;
                end
                else
                begin
                    lvl_next      = lvl_reg + 2'd1;
                    cur_page_next = link_ptr.page;
                    state_next    = ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_size_next   = res_size_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            m_valid_reg    <= 1'b0;
            root_reg       <= 6'd0;
            base_reg       <= 40'd0;
            pool_first_reg <= 7'd1;
            pool_count_reg <= 7'd63;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROOT_PAGE:  root_reg       <= cfg_data[5:0];
                    CFG_STORE_BASE: base_reg       <= cfg_data;
                    CFG_POOL_FIRST: pool_first_reg <= cfg_data[6:0];
                    CFG_POOL_COUNT: pool_count_reg <= cfg_data[6:0];
                    default:        root_reg       <= root_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        va_reg         <= va_next;
        tgt_reg        <= tgt_next;
        lvl_reg        <= lvl_next;
        cur_page_reg   <= cur_page_next;
        e0_reg         <= e0_next;
        fresh_reg      <= fresh_next;
        cnt_reg        <= cnt_next;
        acc_reg        <= acc_next;
        step_reg       <= step_next;
        flags_reg      <= flags_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_size_reg   <= res_size_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_size_reg   <= out_size_next;
    end
endmodule

>>> hw/rtl/fltw_checker.sv
// Port-level checker for the page table walker core, bound to the top level.
// Depends on fltw_pkg and four_level_page_table_walker_core.
module fltw_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata
);
    import fltw_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat accepted before the first finished");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a beat in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != STAT_OK
        |-> m_axis_tdata[53:2] == 52'd0 && m_axis_tdata[55:54] == PSIZE_4K)
        else $error("failed result carries an address or size");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:54] != 2'd3)
        else $error("undefined page size code");
endmodule

bind four_level_page_table_walker_core fltw_checker u_fltw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/testbench.sv
// Self-checking testbench for four_level_page_table_walker_core: loads, walks and maps
// are predicted by a local model of the table store and compared beat by beat.
// Depends on fltw_pkg and the walker RTL only.
module testbench;
    import fltw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES = 64;
    localparam int SLOTS = PAGES * 512;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [51:0] MASK_4K = ~52'hFFF;
    localparam logic [51:0] MASK_2M = ~52'h1FFFFF;
    localparam logic [51:0] MASK_1G = ~52'h3FFFFFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [51:0] addr;
        logic [1:0]  psize;
    } walk_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [183:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [39:0]  cfg_data = '0;

    logic [63:0]  pt_mem [SLOTS];
    bit           pt_known [SLOTS];
    logic [5:0]   root_pg;
    logic [39:0]  base_pg;
    logic [6:0]   pool_first;
    logic [6:0]   pool_count;
    logic [6:0]   pool_used;

    walk_result_t expected_q [$];
    int           errors = 0;
    int           hold_req = 0;
    bit           no_idle = 0;
    int           idle_cycles = 0;

    four_level_page_table_walker_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int slot(int unsigned pg, logic [8:0] idx);
        return (pg * 512 + idx) % SLOTS;
    endfunction

    function automatic bit table_of(logic [63:0] e, output int unsigned pg);
        logic [39:0] pn;
        pn = e[51:12];
        pg = 0;
        if (pn < base_pg || pn - base_pg >= PAGES)
            return 0;
        pg = 32'(pn - base_pg);
        return 1;
    endfunction

    function automatic logic [63:0] page_phys(int unsigned pg);
        logic [39:0] pn;
        pn = base_pg + 40'(pg);
        return {12'h0, pn, 12'h0};
    endfunction

    function automatic void store_entry(int s, logic [63:0] v);
        pt_mem[s] = v;
        pt_known[s] = 1;
    endfunction

    function automatic void fill_page(int unsigned pg, logic [51:0] first, logic [51:0] step,
                                      logic [51:0] mask, logic [7:0] flags);
        logic [51:0] a;
        for (int i = 0; i < 512; i++)
        begin
            a = (first + 52'(i) * step) & mask;
            store_entry(slot(pg, 9'(i)), (step != 0) ? ({12'h0, a} | 64'(flags)) : 64'h0);
        end
    endfunction

    function automatic logic [1:0] pool_take(output int unsigned pg);
        int unsigned p;
        pg = 0;
        if (pool_used >= pool_count)
            return STAT_EXHAUSTED;
        p = 32'(pool_first) + 32'(pool_used);
        if (p >= PAGES)
            return STAT_OUTSIDE;
        pool_used = pool_used + 7'd1;
        pg = p;
        return STAT_OK;
    endfunction

    function automatic logic [1:0] walk_translate(logic [47:0] va, output logic [51:0] pa,
                                                  output logic [1:0] sz);
        int unsigned pg;
        logic [63:0] e;
        pa = '0;
        sz = PSIZE_4K;
        e = pt_mem[slot(root_pg, va[47:39])];
        if (!e[0]) return STAT_NOTPRESENT;
        if (!table_of(e, pg)) return STAT_OUTSIDE;
        e = pt_mem[slot(pg, va[38:30])];
        if (!e[0]) return STAT_NOTPRESENT;
        if (e[7])
        begin
            pa = (e[51:0] & MASK_1G) + {22'h0, va[29:0]};
            sz = PSIZE_1G;
            return STAT_OK;
        end
        if (!table_of(e, pg)) return STAT_OUTSIDE;
        e = pt_mem[slot(pg, va[29:21])];
        if (!e[0]) return STAT_NOTPRESENT;
        if (e[7])
        begin
            pa = (e[51:0] & MASK_2M) + {31'h0, va[20:0]};
            sz = PSIZE_2M;
            return STAT_OK;
        end
        if (!table_of(e, pg)) return STAT_OUTSIDE;
        e = pt_mem[slot(pg, va[20:12])];
        if (!e[0]) return STAT_NOTPRESENT;
        pa = (e[51:0] & MASK_4K) + {40'h0, va[11:0]};
        return STAT_OK;
    endfunction

    function automatic logic [1:0] walk_map(logic [47:0] va, logic [51:0] tgt);
        int unsigned pg, fresh;
        int s;
        logic [1:0] st;
        logic [63:0] e;
        s = slot(root_pg, va[47:39]);
        e = pt_mem[s];
        if (va[47:39] != 0 && e[0] && (pt_mem[slot(root_pg, 9'd0)][51:0] & MASK_4K)
                == (e[51:0] & MASK_4K))
        begin
            store_entry(s, 64'h0);
            e = '0;
        end
        if (!e[0])
        begin
            st = pool_take(fresh);
            if (st != STAT_OK) return st;
            fill_page(fresh, '0, STEP_1G, MASK_1G, FLAGS_LARGE);
            e = page_phys(fresh) | 64'(FLAGS_TABLE);
            store_entry(s, e);
        end
        if (!table_of(e, pg)) return STAT_OUTSIDE;
        s = slot(pg, va[38:30]);
        e = pt_mem[s];
        if (!e[0] || e[7])
        begin
            st = pool_take(fresh);
            if (st != STAT_OK) return st;
            if (e[7])
                fill_page(fresh, e[51:0] & MASK_1G, STEP_2M, MASK_2M, FLAGS_LARGE);
            else
                fill_page(fresh, '0, '0, '0, FLAGS_NONE);
            e = page_phys(fresh) | 64'(FLAGS_TABLE);
            store_entry(s, e);
        end
        if (!table_of(e, pg)) return STAT_OUTSIDE;
        s = slot(pg, va[29:21]);
        e = pt_mem[s];
        if (!e[0] || e[7])
        begin
            st = pool_take(fresh);
            if (st != STAT_OK) return st;
            if (e[7])
                fill_page(fresh, e[51:0] & MASK_2M, STEP_4K, MASK_4K, FLAGS_TABLE);
            else
                fill_page(fresh, '0, '0, '0, FLAGS_NONE);
            e = page_phys(fresh) | 64'(FLAGS_TABLE);
            store_entry(s, e);
        end
        if (!table_of(e, pg)) return STAT_OUTSIDE;
        store_entry(slot(pg, va[20:12]), {12'h0, tgt & MASK_4K} | 64'(FLAGS_TABLE));
        return STAT_OK;
    endfunction

    // first store slot that a walk or map would read before it is written, else -1
    function automatic int unknown_read(logic [1:0] op, logic [47:0] va);
        int unsigned pg;
        int s;
        logic [63:0] e;
        s = slot(root_pg, va[47:39]);
        if (!pt_known[s]) return s;
        e = pt_mem[s];
        if (op == OP_MAP && va[47:39] != 0 && e[0])
        begin
            if (!pt_known[slot(root_pg, 9'd0)]) return slot(root_pg, 9'd0);
            if ((pt_mem[slot(root_pg, 9'd0)][51:0] & MASK_4K) == (e[51:0] & MASK_4K))
                return -1;
        end
        if (!e[0] || !table_of(e, pg)) return -1;
        s = slot(pg, va[38:30]);
        if (!pt_known[s]) return s;
        e = pt_mem[s];
        if (!e[0] || e[7] || !table_of(e, pg)) return -1;
        s = slot(pg, va[29:21]);
        if (!pt_known[s]) return s;
        e = pt_mem[s];
        if (op == OP_MAP || !e[0] || e[7] || !table_of(e, pg)) return -1;
        s = slot(pg, va[20:12]);
        if (!pt_known[s]) return s;
        return -1;
    endfunction

    function automatic logic [63:0] random_entry();
        logic [63:0] e;
        e = {$urandom, $urandom};
        if ($urandom_range(0, 9) != 0)
        begin
            e[51:0] = {base_pg + 40'($urandom_range(0, PAGES - 1)), e[11:0]};
            e[0] = ($urandom_range(0, 7) != 0);
            e[7] = ($urandom_range(0, 3) == 0);
        end
        return e;
    endfunction

    function automatic logic [8:0] pick_index();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 9'd0;
            4, 5:       return 9'd1;
            6:          return 9'd2;
            7:          return 9'd511;
            default:    return 9'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] pick_va();
        if ($urandom_range(0, 9) == 0)
            return 48'({$urandom, $urandom});
        return {pick_index(), pick_index(), pick_index(), 9'($urandom), 12'($urandom)};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    task automatic send_beat(logic [1:0] op, logic [47:0] va, logic [51:0] tgt,
                             logic [5:0] lpage, logic [8:0] lidx, logic [63:0] ldata);
        walk_result_t r;
        int gap;
        r = '0;
        case (op)
            OP_LOAD:      store_entry(slot(lpage, lidx), ldata);
            OP_TRANSLATE: r.status = walk_translate(va, r.addr, r.psize);
            OP_MAP:       r.status = walk_map(va, tgt);
            default:      ;
        endcase
        if (r.status != STAT_OK)
        begin
            r.addr = '0;
            r.psize = PSIZE_4K;
        end
        expected_q.push_back(r);
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {5'h0, ldata, lidx, lpage, tgt, va};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic load_entry(int s, logic [63:0] v);
        send_beat(OP_LOAD, 48'($urandom), 52'({$urandom, $urandom}), 6'(s / 512),
                  9'(s % 512), v);
    endtask

    // fill in any entry the operation would otherwise read undefined
    task automatic run_op(logic [1:0] op, logic [47:0] va, logic [51:0] tgt);
        int s;
        if (op == OP_TRANSLATE || op == OP_MAP)
        begin
            s = unknown_read(op, va);
            while (s >= 0)
            begin
                load_entry(s, random_entry());
                s = unknown_read(op, va);
            end
        end
        send_beat(op, va, tgt, 6'($urandom), 9'($urandom), {$urandom, $urandom});
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apply_config(logic [5:0] root, logic [39:0] base, logic [6:0] first,
                                logic [6:0] count);
        logic [39:0] vals [4];
        vals = '{40'(root), base, 40'(first), 40'(count)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        root_pg = root;
        base_pg = base;
        pool_first = first;
        pool_count = count;
    endtask

    function automatic logic [47:0] make_va(int i4, int i3, int i2, int i1, int off);
        return {9'(i4), 9'(i3), 9'(i2), 9'(i1), 12'(off)};
    endfunction

    function automatic logic [63:0] table_ptr(int pg, logic [7:0] flags);
        return page_phys(pg) | 64'(flags);
    endfunction

    task automatic test_directed_walks();
        apply_config(6'd0, 40'd0, 7'd20, 7'd40);
        load_entry(slot(0, 0), table_ptr(5, FLAGS_TABLE));
        load_entry(slot(0, 1), 64'h0);
        load_entry(slot(0, 2), table_ptr(100, FLAGS_TABLE));
        load_entry(slot(0, 511), table_ptr(5, FLAGS_TABLE));
        load_entry(slot(5, 0), 64'h0000_0000_C000_0083);
        load_entry(slot(5, 1), table_ptr(6, FLAGS_TABLE));
        load_entry(slot(6, 0), 64'h8000_0000_0060_0083);
        load_entry(slot(6, 1), table_ptr(7, FLAGS_TABLE));
        load_entry(slot(7, 3), 64'hFFF0_000A_BCDE_0FFF);
        run_op(OP_TRANSLATE, make_va(0, 0, 5, 9, 'h123), '0);
        run_op(OP_TRANSLATE, make_va(0, 1, 0, 511, 'hFFF), '0);
        run_op(OP_TRANSLATE, make_va(0, 1, 1, 3, 'h456), '0);
        run_op(OP_TRANSLATE, make_va(1, 0, 0, 0, 0), '0);
        run_op(OP_TRANSLATE, make_va(2, 0, 0, 0, 0), '0);
        run_op(OP_MAP, make_va(0, 0, 7, 9, 0), 52'hF_FFFF_FFFF_FFFF);
        run_op(OP_TRANSLATE, make_va(0, 0, 7, 9, 'hABC), '0);
        run_op(OP_TRANSLATE, make_va(0, 0, 7, 10, 'h1), '0);
        run_op(OP_MAP, make_va(1, 3, 4, 5, 0), 52'h0_0000_1234_5000);
        run_op(OP_TRANSLATE, make_va(1, 3, 4, 5, 'h777), '0);
        run_op(OP_MAP, make_va(511, 511, 511, 511, 'hFFF), 52'h0);
        run_op(OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0);
        run_op(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_random_mix(int count);
        int s;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2, 3:
                    load_entry(slot(root_pg, pick_index()), random_entry());
                4, 5:
                begin
                    s = $urandom_range(0, SLOTS - 1);
                    load_entry(s, random_entry());
                end
                6, 7, 8, 9, 10, 11, 12:
                    run_op(OP_TRANSLATE, pick_va(), '0);
                13, 14, 15, 16, 17, 18:
                    run_op(OP_MAP, pick_va(), 52'({$urandom, $urandom}));
                default:
                    run_op(OP_UNUSED, pick_va(), 52'({$urandom, $urandom}));
            endcase
        end
        no_idle = 0;
        wait_idle();
    endtask

    task automatic test_config_sweep();
        apply_config(6'd63, 40'd0, 7'd0, 7'd6);
        test_random_mix(100);
        apply_config(6'($urandom), 40'($urandom_range(1, 1000)), 7'd10, 7'd5);
        test_random_mix(100);
        apply_config(6'd17, 40'hFF_FFFF_FFFF, 7'd64, 7'd64);
        test_random_mix(80);
        apply_config(6'd3, 40'hFF_FFFF_FFC0, 7'd30, 7'd0);
        test_random_mix(80);
        apply_config(6'd0, 40'h55_5555_5555, 7'd40, 7'd64);
        test_random_mix(80);
        apply_config(6'd9, 40'd0, 7'd0, 7'd64);
        test_random_mix(160);
    endtask

    task automatic test_output_hold();
        hold_req = 300;
        no_idle = 1;
        for (int n = 0; n < 30; n++)
            run_op(OP_TRANSLATE, pick_va(), '0);
        no_idle = 0;
        wait_idle();
    endtask

    task automatic test_drain_pause();
        for (int n = 0; n < 8; n++)
            run_op(($urandom_range(0, 1) != 0) ? OP_TRANSLATE : OP_MAP, pick_va(),
                   52'({$urandom, $urandom}));
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        for (int n = 0; n < 8; n++)
            run_op(OP_TRANSLATE, pick_va(), '0);
        wait_idle();
    endtask

    // result side: random stalls, plus one long hold when asked
    initial
    begin
        int w;
        forever
        begin
            w = $urandom_range(0, 4);
            if (hold_req > 0)
            begin
                w = hold_req;
                hold_req = 0;
            end
            if (w > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        walk_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected beat", 64'(m_axis_tdata), 64'h0);
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tdata[1:0] != want.status)
                    report_mismatch("status", 64'(m_axis_tdata[1:0]), 64'(want.status));
                if (m_axis_tdata[53:2] != want.addr)
                    report_mismatch("result_addr", 64'(m_axis_tdata[53:2]), 64'(want.addr));
                if (m_axis_tdata[55:54] != want.psize)
                    report_mismatch("page_size", 64'(m_axis_tdata[55:54]), 64'(want.psize));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            pt_mem[i] = '0;
            pt_known[i] = 0;
        end
        root_pg = '0;
        base_pg = '0;
        pool_first = 7'd1;
        pool_count = 7'd63;
        pool_used = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed_walks();
        test_output_hold();
        test_config_sweep();
        test_drain_pause();
        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/fltw_pkg.sv
hw/rtl/fltw_ram.sv
hw/rtl/four_level_page_table_walker_core.sv
hw/rtl/fltw_checker.sv
tb/testbench.sv
